>>> rtl/core/gdw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gdw_pkg: shared types and calendar helpers
// Beat payloads, error codes, the inter-cell record and the month length table.
// ----------------------------------------------------------------------------
package gdw_pkg;

   localparam int unsigned MONTHS = 12;

   typedef enum logic [2:0] {
      ERR_NONE       = 3'd0,
      ERR_DAY_LOW    = 3'd1,
      ERR_DAY_HIGH   = 3'd2,
      ERR_DAY_COMMON = 3'd3,
      ERR_YEAR_LOW   = 3'd4,
      ERR_YEAR_HIGH  = 3'd5,
      ERR_MONTH      = 3'd6
   } err_type;

   localparam logic OP_ORDINAL   = 1'b0;
   localparam logic OP_MONTH_DAY = 1'b1;

   localparam logic [13:0] YEAR_MAX    = 14'd9999;
   localparam logic [8:0]  DAY_MAX     = 9'd366;
   localparam logic [3:0]  MONTH_FIRST = 4'd1;
   localparam logic [3:0]  MONTH_LAST  = 4'd12;
   localparam logic [3:0]  MONTH_FEB   = 4'd2;

   typedef struct packed {
      logic        op;
      logic [13:0] year_in;
      logic [3:0]  month_in;
      logic [8:0]  day_in;
   } req_type;

   typedef struct packed {
      logic [3:0] month_out;
      logic [4:0] day_of_month;
      logic [2:0] weekday;
      logic [8:0] day_of_year;
      logic       leap;
      logic [2:0] error_code;
   } rsp_type;

   // Record handed from cell to cell.
   typedef struct packed {
      logic       vld;
      logic       op;
      logic       leap;
      err_type    err;
      logic [3:0] month;   // target month (month-day mode) or resolved month
      logic       done;    // ordinal mode: month already resolved
      logic [8:0] dom;     // remaining day count / day of month
      logic [8:0] doy;     // running day of year
      logic [4:0] dd;      // year doomsday sum, not yet reduced mod 7
   } cell_type;

   function automatic logic [4:0] days_in(input logic [3:0] m, input logic lp);
      logic [4:0] d;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                     d = 5'd30;
         4'd2:    d = lp ? 5'd29 : 5'd28;
         default: d = 5'd31;
      endcase
      return d;
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/gregorian_date_weekday_converter_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gregorian_date_weekday_converter_core: date resolve, validate and weekday
// Takes a year with either an ordinal day or a month and day, and returns
// month, day of month, day of year, leap flag and doomsday weekday.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+----------------------------
//   req_     | in        | req_valid / req_ready | gdw_pkg::req_type req_data
//   rsp_     | out       | rsp_valid / rsp_ready | gdw_pkg::rsp_type rsp_data
//
// The row holds two front stages, twelve month cells and the result register.
// The whole row advances together, so a new beat enters every cycle while
// rsp_ready stays high; with a result waiting and rsp_ready low the row holds
// and req_ready drops.
// Reset clears only the valid bits of each stage; no clearing pass follows.
//
module gregorian_date_weekday_converter_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire gdw_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output gdw_pkg::rsp_type       rsp_data
);

   // advance the row when the result slot is free or being taken
   logic              adv;
   gdw_pkg::cell_type chain [gdw_pkg::MONTHS+1];

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // decode the year and validate; seeds the first month cell
   gdw_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_vld   (req_valid),
      .in_data  (req_data),
      .out_cell (chain[0])
   );

   // one cell per month, January first
   for (genvar g = 0; g < gdw_pkg::MONTHS; g++) begin : g_cell
      gdw_month_cell #(
         .MONTH_IDX (g + 1)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (adv),
         .in_cell  (chain[g]),
         .out_cell (chain[g+1])
      );
   end

   // weekday and result register
   gdw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_cell   (chain[gdw_pkg::MONTHS]),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // a failed date carries nothing but its error code
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error_code != gdw_pkg::ERR_NONE |->
         rsp_data.month_out == 4'd0 && rsp_data.day_of_month == 5'd0 &&
         rsp_data.weekday == 3'd0 && rsp_data.day_of_year == 9'd0 && !rsp_data.leap)
      else $error("error beat with nonzero fields");

   // a good date resolves to a real month and day
   a_ok_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error_code == gdw_pkg::ERR_NONE |->
         rsp_data.month_out >= gdw_pkg::MONTH_FIRST &&
         rsp_data.month_out <= gdw_pkg::MONTH_LAST &&
         rsp_data.day_of_month != 5'd0 && rsp_data.weekday <= 3'd6 &&
         rsp_data.day_of_year != 9'd0 && rsp_data.day_of_year <= gdw_pkg::DAY_MAX)
      else $error("good beat out of calendar range");

   // a common year never reaches day 366
   a_common_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error_code == gdw_pkg::ERR_NONE && !rsp_data.leap |->
         rsp_data.day_of_year < gdw_pkg::DAY_MAX)
      else $error("day 366 in a common year");

   // day of month never exceeds its month's length
   a_dom_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error_code == gdw_pkg::ERR_NONE |->
         rsp_data.day_of_month <= gdw_pkg::days_in(rsp_data.month_out, rsp_data.leap))
      else $error("day of month past month end");

endmodule
`default_nettype wire

>>> rtl/core/gdw_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gdw_front: year decode and date validation
// Two stages: split the year into century and year of century, then derive the
// leap flag, the error code and the doomsday sum, and seed the cell record.
// ----------------------------------------------------------------------------
module gdw_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_vld,
   input  wire gdw_pkg::req_type  in_data,
   output gdw_pkg::cell_type      out_cell
);

   // stage 1 registers
   logic             vld1_ff;
   gdw_pkg::req_type req1_ff;
   logic [7:0]       cent1_ff;
   logic [26:0]      prod_in;

   // stage 2 register
   gdw_pkg::cell_type cell_ff, cell_in;

   // year / 100 by reciprocal, exact for every 14-bit year
   assign prod_in = {13'd0, in_data.year_in} * 27'd5243;

   function automatic logic [2:0] century_anchor(input logic [1:0] c);
      logic [2:0] a;
      case (c)
         2'd0:    a = 3'd2;
         2'd1:    a = 3'd0;
         2'd2:    a = 3'd5;
         default: a = 3'd3;
      endcase
      return a;
   endfunction

   always_comb begin
      logic [13:0] yrem;
      logic [6:0]  yy;
      logic [12:0] p12;
      logic [3:0]  q12;
      logic [6:0]  r12;
      logic [3:0]  r;
      logic        lp;
      logic [13:0] y;
      logic [8:0]  day;
      logic [3:0]  mon;
      gdw_pkg::err_type err;

      y    = req1_ff.year_in;
      day  = req1_ff.day_in;
      mon  = req1_ff.month_in;
      yrem = y - ({6'd0, cent1_ff} << 6) - ({6'd0, cent1_ff} << 5)
           - ({6'd0, cent1_ff} << 2);
      yy   = yrem[6:0];
      lp   = (yy == 7'd0) ? (cent1_ff[1:0] == 2'd0) : (y[1:0] == 2'd0);
      // yy / 12 by reciprocal, exact below 100
      p12  = {6'd0, yy} * 13'd43;
      q12  = p12[12:9];
      r12  = yy - ({3'd0, q12} << 3) - ({3'd0, q12} << 2);
      r    = r12[3:0];

      err = gdw_pkg::ERR_NONE;
      if (req1_ff.op == gdw_pkg::OP_ORDINAL) begin
         if (day == 9'd0)                               err = gdw_pkg::ERR_DAY_LOW;
         else if (day > gdw_pkg::DAY_MAX)               err = gdw_pkg::ERR_DAY_HIGH;
         else if (day == gdw_pkg::DAY_MAX && !lp)       err = gdw_pkg::ERR_DAY_COMMON;
         else if (y == 14'd0)                           err = gdw_pkg::ERR_YEAR_LOW;
         else if (y > gdw_pkg::YEAR_MAX)                err = gdw_pkg::ERR_YEAR_HIGH;
      end else begin
         if (y == 14'd0)                                err = gdw_pkg::ERR_YEAR_LOW;
         else if (y > gdw_pkg::YEAR_MAX)                err = gdw_pkg::ERR_YEAR_HIGH;
         else if (mon < gdw_pkg::MONTH_FIRST || mon > gdw_pkg::MONTH_LAST)
                                                        err = gdw_pkg::ERR_MONTH;
         else if (day == 9'd0)                          err = gdw_pkg::ERR_DAY_LOW;
         else if (day > {4'd0, gdw_pkg::days_in(mon, lp)})
                                                        err = gdw_pkg::ERR_DAY_HIGH;
      end

      cell_in.vld   = vld1_ff;
      cell_in.op    = req1_ff.op;
      cell_in.leap  = lp;
      cell_in.err   = err;
      cell_in.month = (req1_ff.op == gdw_pkg::OP_ORDINAL) ? 4'd0 : mon;
      cell_in.done  = 1'b0;
      cell_in.dom   = day;
      cell_in.doy   = day;
      cell_in.dd    = {2'd0, century_anchor(cent1_ff[1:0])} + {1'b0, q12}
                    + {1'b0, r} + {3'd0, r[3:2]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff     <= 1'b0;
         cell_ff.vld <= 1'b0;
      end else if (en) begin
         vld1_ff <= in_vld;
         cell_ff <= cell_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         req1_ff  <= in_data;
         cent1_ff <= prod_in[26:19];
      end
   end

   assign out_cell = cell_ff;

endmodule
`default_nettype wire

>>> rtl/core/gdw_month_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gdw_month_cell: one month of the calendar walk
// Ordinal mode: peel this month's length off the remaining day count or stop
// here. Month-day mode: add this month's length when it precedes the target.
// ----------------------------------------------------------------------------
module gdw_month_cell #(
   parameter int unsigned MONTH_IDX = 1
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire gdw_pkg::cell_type  in_cell,
   output gdw_pkg::cell_type       out_cell
);

   localparam logic [3:0] MONTH_CODE = 4'(MONTH_IDX);
   localparam logic       IS_LAST    = (MONTH_IDX >= gdw_pkg::MONTHS);

   gdw_pkg::cell_type cell_ff, cell_in;
   logic [4:0]        len;

   assign len = gdw_pkg::days_in(MONTH_CODE, in_cell.leap);

   always_comb begin
      cell_in = in_cell;
      if (in_cell.op == gdw_pkg::OP_ORDINAL) begin
         if (!in_cell.done) begin
            if (!IS_LAST && in_cell.dom > {4'd0, len}) begin
               cell_in.dom = in_cell.dom - {4'd0, len};
            end else begin
               cell_in.done  = 1'b1;
               cell_in.month = MONTH_CODE;
            end
         end
      end else if (MONTH_CODE < in_cell.month) begin
         cell_in.doy = in_cell.doy + {4'd0, len};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.vld <= 1'b0;
      end else if (en) begin
         cell_ff <= cell_in;
      end
   end

   assign out_cell = cell_ff;

endmodule
`default_nettype wire

>>> rtl/core/gdw_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gdw_back: weekday and result register
// Apply the month anchor, reduce mod 7, and zero the fields of a failed date.
// ----------------------------------------------------------------------------
module gdw_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire gdw_pkg::cell_type  in_cell,
   output logic                    rsp_valid,
   output gdw_pkg::rsp_type        rsp_data
);

   logic             rsp_valid_ff;
   gdw_pkg::rsp_type rsp_ff, rsp_in;

   function automatic logic [4:0] month_anchor(input logic [3:0] m, input logic lp);
      logic [4:0] a;
      case (m)
         4'd1:    a = lp ? 5'd4 : 5'd3;
         4'd2:    a = lp ? 5'd29 : 5'd28;
         4'd3:    a = 5'd14;
         4'd4:    a = 5'd4;
         4'd5:    a = 5'd9;
         4'd6:    a = 5'd6;
         4'd7:    a = 5'd11;
         4'd8:    a = 5'd8;
         4'd9:    a = 5'd5;
         4'd10:   a = 5'd10;
         4'd11:   a = 5'd7;
         default: a = 5'd12;
      endcase
      return a;
   endfunction

   // x mod 7 by reciprocal, exact for any 7-bit x
   function automatic logic [2:0] mod7(input logic [6:0] x);
      logic [17:0] p;
      logic [6:0]  rem;
      p   = {11'd0, x} * 18'd293;
      rem = x - ({2'd0, p[15:11]} << 3) + {2'd0, p[15:11]};
      return rem[2:0];
   endfunction

   always_comb begin
      logic [6:0] sum;
      sum = {2'd0, in_cell.dd} + {2'd0, in_cell.dom[4:0]} + 7'd28
          - {2'd0, month_anchor(in_cell.month, in_cell.leap)};
      if (in_cell.err != gdw_pkg::ERR_NONE) begin
         rsp_in            = '0;
         rsp_in.error_code = in_cell.err;
      end else begin
         rsp_in.month_out    = in_cell.month;
         rsp_in.day_of_month = in_cell.dom[4:0];
         rsp_in.weekday      = mod7(sum);
         rsp_in.day_of_year  = in_cell.doy;
         rsp_in.leap         = in_cell.leap;
         rsp_in.error_code   = gdw_pkg::ERR_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= in_cell.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

>>> dv/gdw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdw_checker: date converter scoreboard
// Watches both channels, predicts the result of each accepted date beat and
// compares every returned beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module gdw_checker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_ready,
   input  wire gdw_pkg::req_type  req_data,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire gdw_pkg::rsp_type  rsp_data,
   output int                     fail_count,
   output int                     pending,
   output int                     checked_count,
   output int                     invalid_count
);

   gdw_pkg::rsp_type date_results_due[$];

   function automatic bit gregorian_leap(input logic [13:0] y);
      return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
   endfunction

   function automatic int month_length(input int m, input bit lp);
      case (m)
         2:           return lp ? 29 : 28;
         4, 6, 9, 11: return 30;
         default:     return 31;
      endcase
   endfunction

   // Doomsday anchor of each month in a common year.
   function automatic int month_anchor(input int m);
      case (m)
         1: return 3;   2: return 28;  3: return 14;  4: return 4;
         5: return 9;   6: return 6;   7: return 11;  8: return 8;
         9: return 5;   10: return 10; 11: return 7;  default: return 12;
      endcase
   endfunction

   function automatic int day_of_week(input int y, input int m, input int d, input bit lp);
      int yy, r, sum, anchor;
      yy = y % 100;
      r = yy % 12;
      case ((y / 100) % 4)
         0: sum = 2;
         1: sum = 0;
         2: sum = 5;
         default: sum = 3;
      endcase
      sum = (sum + yy / 12 + r + r / 4) % 7;
      anchor = month_anchor(m);
      if (lp && (m == 1 || m == 2)) anchor++;
      return (sum + d + 28 - anchor) % 7;
   endfunction

   function automatic gdw_pkg::rsp_type predict_date_result(input gdw_pkg::req_type q);
      gdw_pkg::rsp_type res;
      gdw_pkg::err_type err;
      bit lp;
      int yr, mon, dy, m, dom, doy;
      yr  = q.year_in;
      mon = q.month_in;
      dy  = q.day_in;
      lp  = gregorian_leap(q.year_in);
      err = gdw_pkg::ERR_NONE;
      m = 0; dom = 0; doy = 0;
      res = '0;
      if (q.op == gdw_pkg::OP_ORDINAL) begin
         if (dy < 1)                 err = gdw_pkg::ERR_DAY_LOW;
         else if (dy > 366)          err = gdw_pkg::ERR_DAY_HIGH;
         else if (dy == 366 && !lp)  err = gdw_pkg::ERR_DAY_COMMON;
         else if (yr < 1)            err = gdw_pkg::ERR_YEAR_LOW;
         else if (yr > 9999)         err = gdw_pkg::ERR_YEAR_HIGH;
         if (err == gdw_pkg::ERR_NONE) begin
            doy = dy;
            dom = dy;
            m = 1;
            while (m < 12 && dom > month_length(m, lp)) begin
               dom -= month_length(m, lp);
               m++;
            end
         end
      end else begin
         if (yr < 1)                              err = gdw_pkg::ERR_YEAR_LOW;
         else if (yr > 9999)                      err = gdw_pkg::ERR_YEAR_HIGH;
         else if (mon < 1 || mon > 12)            err = gdw_pkg::ERR_MONTH;
         else if (dy < 1)                         err = gdw_pkg::ERR_DAY_LOW;
         else if (dy > month_length(mon, lp))     err = gdw_pkg::ERR_DAY_HIGH;
         if (err == gdw_pkg::ERR_NONE) begin
            m = mon;
            dom = dy;
            doy = dy;
            for (int i = 1; i < mon; i++) doy += month_length(i, lp);
         end
      end
      res.error_code = err;
      if (err == gdw_pkg::ERR_NONE) begin
         res.month_out    = 4'(m);
         res.day_of_month = 5'(dom);
         res.weekday      = 3'(day_of_week(yr, m, dom, lp));
         res.day_of_year  = 9'(doy);
         res.leap         = lp;
      end
      return res;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
      checked_count = 0;
      invalid_count = 0;
   end

   always @(posedge clock) begin
      gdw_pkg::rsp_type want;
      if (reset) begin
         date_results_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (date_results_due.size() == 0) begin
               $display("%0t: unexpected result beat %h", $time, rsp_data);
               fail_count++;
            end else begin
               want = date_results_due.pop_front();
               check_field("month_out", want.month_out, rsp_data.month_out);
               check_field("day_of_month", want.day_of_month, rsp_data.day_of_month);
               check_field("weekday", want.weekday, rsp_data.weekday);
               check_field("day_of_year", want.day_of_year, rsp_data.day_of_year);
               check_field("leap", want.leap, rsp_data.leap);
               check_field("error_code", want.error_code, rsp_data.error_code);
               checked_count++;
               if (want.error_code != gdw_pkg::ERR_NONE) invalid_count++;
            end
         end
         if (req_valid && req_ready)
            date_results_due.push_back(predict_date_result(req_data));
      end
      pending = date_results_due.size();
   end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: date converter testbench
// Drives directed and random date beats with random gaps and back-pressure;
// the checker beside the core predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int RANDOM_DATES = 1750;
   localparam int HOLD_AT      = 300;    // receiver stalls once this many beats are in
   localparam int HOLD_CYCLES  = 80;     // long enough to fill the whole row
   localparam int STEADY_FIRST = 900;    // no idling on either side in this window
   localparam int STEADY_LAST  = 1200;
   localparam int DRAIN_AT     = 1400;   // sender waits for all results here
   localparam int TAIL_CYCLES  = 40;     // margin for the row after the last result

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   gdw_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   gdw_pkg::rsp_type rsp_data;

   int fail_count, pending, checked_count, invalid_count;
   int sent_count;
   int ordinal_count, month_day_count;

   gregorian_date_weekday_converter_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   gdw_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending       (pending),
      .checked_count (checked_count),
      .invalid_count (invalid_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hold reset at the start, then release it on a falling edge.
   initial begin
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Fixed ceiling on the run; far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic bit in_steady_window();
      return sent_count >= STEADY_FIRST && sent_count < STEADY_LAST;
   endfunction

   // Receiver: random stalls, one long hold-off counted here, and a quiet
   // window with ready held high.
   initial begin
      int hold_left;
      bit held;
      hold_left = 0;
      held = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && sent_count >= HOLD_AT) begin
            held = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (in_steady_window()) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= 11);
         end
      end
   end

   function automatic gdw_pkg::req_type make_date(input logic op, input int y, input int m,
                                                  input int d);
      gdw_pkg::req_type q;
      q.op       = op;
      q.year_in  = 14'(y);
      q.month_in = 4'(m);
      q.day_in   = 9'(d);
      return q;
   endfunction

   // Mostly well-formed dates with random content; the rest is either raw
   // noise on every bit or a date pushed just past a boundary.
   function automatic gdw_pkg::req_type random_date();
      int pick, y, m, d, len;
      bit lp;
      logic op;
      pick = $urandom_range(99);
      if (pick < 18)
         return make_date(1'($urandom), $urandom, $urandom, $urandom);
      op = 1'($urandom_range(1));
      if ($urandom_range(3) == 0) y = 100 * $urandom_range(1, 99);
      else                        y = $urandom_range(1, 9999);
      lp = (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
      m = $urandom_range(1, 12);
      if (op == gdw_pkg::OP_ORDINAL) begin
         len = lp ? 366 : 365;
         d = (pick < 28) ? len + 1 : $urandom_range(1, len);
         if ($urandom_range(9) == 0) d = ($urandom_range(1)) ? 1 : len;
         return make_date(op, y, $urandom_range(15), d);
      end
      len = gdw_pkg::days_in(4'(m), lp);
      d = (pick < 28) ? len + 1 : $urandom_range(1, len);
      if ($urandom_range(9) == 0) d = ($urandom_range(1)) ? 1 : len;
      return make_date(op, y, m, d);
   endfunction

   // Offer one beat: maybe idle first, then hold valid until accepted.
   // Enters and leaves on a falling edge.
   task automatic send_date(input gdw_pkg::req_type q);
      while (!in_steady_window() && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= q;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
      if (q.op == gdw_pkg::OP_ORDINAL) ordinal_count++;
      else                             month_day_count++;
      @(negedge clock);
   endtask

   // Drop valid and wait until every predicted result is back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   initial begin
      req_valid = 1'b0;
      req_data = '0;
      sent_count = 0;
      ordinal_count = 0;
      month_day_count = 0;
      @(negedge reset);
      @(negedge clock);

      // Directed: field extremes, every error code, leap corner cases.
      send_date(make_date(gdw_pkg::OP_ORDINAL,   2024,  0,   1));
      send_date(make_date(gdw_pkg::OP_ORDINAL,   2024,  0, 366));   // last day, leap year
      send_date(make_date(gdw_pkg::OP_ORDINAL,   2023,  0, 365));
      send_date(make_date(gdw_pkg::OP_ORDINAL,   2023,  0, 366));   // day 366, common year
      send_date(make_date(gdw_pkg::OP_ORDINAL,   2023,  0,   0));   // day below one
      send_date(make_date(gdw_pkg::OP_ORDINAL,   2023,  0, 367));   // day above 366
      send_date(make_date(gdw_pkg::OP_ORDINAL,      0, 15, 511));
      send_date(make_date(gdw_pkg::OP_ORDINAL,      0,  0, 366));   // raw year zero is leap
      send_date(make_date(gdw_pkg::OP_ORDINAL,      0,  0, 100));
      send_date(make_date(gdw_pkg::OP_ORDINAL,  10000,  0, 366));   // leap but out of range
      send_date(make_date(gdw_pkg::OP_ORDINAL,  16383, 15,  60));
      send_date(make_date(gdw_pkg::OP_ORDINAL,      1,  0,   1));
      send_date(make_date(gdw_pkg::OP_ORDINAL,   9999, 15, 365));   // month ignored here
      send_date(make_date(gdw_pkg::OP_MONTH_DAY, 2000,  2,  29));   // divisible by 400
      send_date(make_date(gdw_pkg::OP_MONTH_DAY, 1900,  2,  29));   // century, not leap
      send_date(make_date(gdw_pkg::OP_MONTH_DAY,    0,  0,   0));
      send_date(make_date(gdw_pkg::OP_MONTH_DAY, 16383, 15, 511));
      send_date(make_date(gdw_pkg::OP_MONTH_DAY, 9999, 12,  31));
      send_date(make_date(gdw_pkg::OP_MONTH_DAY,    1,  1,   1));
      send_date(make_date(gdw_pkg::OP_MONTH_DAY, 2024,  0,  10));   // month zero
      send_date(make_date(gdw_pkg::OP_MONTH_DAY, 2024, 13,  10));
      send_date(make_date(gdw_pkg::OP_MONTH_DAY, 2024, 15,   0));   // month error first
      send_date(make_date(gdw_pkg::OP_MONTH_DAY, 2024,  4,   0));
      send_date(make_date(gdw_pkg::OP_MONTH_DAY, 2024,  4,  31));
      send_date(make_date(gdw_pkg::OP_MONTH_DAY, 2023,  6, 511));
      drain_results();

      for (int i = 0; i < RANDOM_DATES; i++) begin
         if (sent_count == DRAIN_AT) drain_results();
         send_date(random_date());
      end
      req_valid <= 1'b0;

      // Wait for the tail, then give the row time to show any stray beat.
      while (pending != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d dates (%0d ordinal, %0d month-day) under random gaps and stalls;",
               sent_count, ordinal_count, month_day_count);
      $display("checked %0d result beats, %0d of them flagged invalid.",
               checked_count, invalid_count);
      if (fail_count == 0 && pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/core/gdw_pkg.sv
rtl/core/gdw_front.sv
rtl/core/gdw_month_cell.sv
rtl/core/gdw_back.sv
rtl/core/gregorian_date_weekday_converter_core.sv
dv/gdw_checker.sv
dv/tb_top.sv
